>>> rtl/first_fit_byte_map_allocator_top_defines.svh
// Assertion macros for the first-fit allocator.
`ifndef FIRST_FIT_BYTE_MAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BYTE_MAP_ALLOCATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFBA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFBA_ASSERT(lbl, clk, rstn, prop, msg)
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/ffba_pkg.sv
// Shared constants and types of the first-fit allocator.
package ffba_pkg;

    localparam int HEAP_CELLS = 1024;
    localparam int ADDR_W     = $clog2(HEAP_CELLS);
    localparam int SIZE_W     = 11;
    localparam int IDX_W      = 10;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = (ADDR_W + 1 > SIZE_W) ? ADDR_W + 1 : SIZE_W;

    typedef logic [STAT_W-1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NOROOM  = 2'd1;
    localparam t_status ST_BADFREE = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic used;
        logic head;
    } t_cell;

    typedef struct packed {
        logic              cell_we;
        logic [ADDR_W-1:0] cell_waddr;
        t_cell             cell_wdata;
        logic              len_we;
        logic [ADDR_W-1:0] len_waddr;
        logic [SIZE_W-1:0] len_wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

>>> rtl/ffba_if.sv
// Request and response channel interfaces of the first-fit allocator.
interface ffba_req_if;
    import ffba_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic [SIZE_W-1:0] request_size;
    logic [IDX_W-1:0]  block_start;

    modport source (output valid, output mode, output request_size, output block_start,
                    input ready);
    modport sink (input valid, input mode, input request_size, input block_start,
                  output ready);
endinterface

interface ffba_rsp_if;
    import ffba_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  base_index;

    modport source (output valid, output status, output base_index, input ready);
    modport sink (input valid, input status, input base_index, output ready);
endinterface

>>> rtl/ffba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ffba_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ffba_ctrl.sv
// Sequencer: clearing pass, first-fit scan, run marking and block release.
module ffba_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ffba_req_if.sink                 i_req,
    ffba_rsp_if.source               o_rsp,
    output ffba_pkg::t_mem_req       o_mem,
    input  ffba_pkg::t_cell          i_cell,
    input  logic [ffba_pkg::SIZE_W-1:0] i_len
);
    import ffba_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_MARK     = 7'b0001000,
        S_FREE_CHK = 7'b0010000,
        S_FREE_CLR = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(HEAP_CELLS - 1);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_chk, n_chk;
    logic              r_chk_v, n_chk_v;
    logic [CNT_W-1:0]  r_run, n_run;
    logic [CNT_W-1:0]  r_from, n_from;
    logic [CNT_W-1:0]  r_size, n_size;
    logic [ADDR_W-1:0] r_wptr, n_wptr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_first, n_first;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_start, n_start;
    logic              r_rsp_valid, n_rsp_valid;
    t_status           r_rsp_status, n_rsp_status;
    logic [IDX_W-1:0]  r_rsp_start, n_rsp_start;
    logic [CNT_W-1:0]  w_size_ext;
    logic [CNT_W-1:0]  w_idx_ext;
    logic [CNT_W-1:0]  w_run_inc;

    assign w_size_ext = CNT_W'(i_req.request_size);
    assign w_idx_ext  = CNT_W'(i_req.block_start);
    assign w_run_inc  = r_run + CNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_chk        = r_chk;
        n_chk_v      = r_chk_v;
        n_run        = r_run;
        n_from       = r_from;
        n_size       = r_size;
        n_wptr       = r_wptr;
        n_cnt        = r_cnt;
        n_first      = r_first;
        n_status     = r_status;
        n_start      = r_start;
        n_rsp_valid  = r_rsp_valid;
        n_rsp_status = r_rsp_status;
        n_rsp_start  = r_rsp_start;
        o_mem        = '0;

        if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_mem.cell_we    = 1'b1;
                o_mem.cell_waddr = r_wptr;
                if (r_wptr == LAST_CELL) begin
                    n_state = S_IDLE;
                end else begin
                    n_wptr = r_wptr + ADDR_W'(1);
                end
            end
            S_IDLE: begin
                o_mem.raddr = ADDR_W'(i_req.block_start);
                if (i_req.valid) begin
                    if (i_req.mode == MODE_ALLOC) begin
                        if (w_size_ext == '0 || w_size_ext > CNT_W'(HEAP_CELLS)) begin
                            n_status = ST_NOROOM;
                            n_start  = '0;
                            n_state  = S_DONE;
                        end else begin
                            n_size  = w_size_ext;
                            n_ptr   = '0;
                            n_chk_v = 1'b0;
                            n_run   = '0;
                            n_from  = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (w_idx_ext >= CNT_W'(HEAP_CELLS)) begin
                            n_status = ST_BADFREE;
                            n_start  = '0;
                            n_state  = S_DONE;
                        end else begin
                            n_wptr  = ADDR_W'(i_req.block_start);
                            n_state = S_FREE_CHK;
                        end
                    end
                end
            end
            S_SCAN: begin
                o_mem.raddr = r_ptr[ADDR_W-1:0];
                if (r_ptr < CNT_W'(HEAP_CELLS)) begin
                    n_ptr   = r_ptr + CNT_W'(1);
                    n_chk   = r_ptr[ADDR_W-1:0];
                    n_chk_v = 1'b1;
                end else begin
                    n_chk_v = 1'b0;
                end
                if (r_chk_v) begin
                    if (!i_cell.used && w_run_inc == r_size) begin
                        n_wptr  = ADDR_W'(r_from);
                        n_start = ADDR_W'(r_from);
                        n_cnt   = r_size;
                        n_first = 1'b1;
                        n_state = S_MARK;
                    end else begin
                        if (i_cell.used) begin
                            n_run  = '0;
                            n_from = CNT_W'(r_chk) + CNT_W'(1);
                        end else begin
                            n_run = w_run_inc;
                        end
                        if (r_chk == LAST_CELL) begin
                            n_status = ST_NOROOM;
                            n_start  = '0;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_MARK: begin
                o_mem.cell_we         = 1'b1;
                o_mem.cell_waddr      = r_wptr;
                o_mem.cell_wdata.used = 1'b1;
                o_mem.cell_wdata.head = r_first;
                o_mem.len_we          = r_first;
                o_mem.len_waddr       = r_wptr;
                o_mem.len_wdata       = SIZE_W'(r_size);
                n_first               = 1'b0;
                if (r_cnt == CNT_W'(1)) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_cnt  = r_cnt - CNT_W'(1);
                    n_wptr = r_wptr + ADDR_W'(1);
                end
            end
            S_FREE_CHK: begin
                if (i_cell.head) begin
                    n_cnt   = CNT_W'(i_len);
                    n_start = r_wptr;
                    n_state = S_FREE_CLR;
                end else begin
                    n_status = ST_BADFREE;
                    n_start  = '0;
                    n_state  = S_DONE;
                end
            end
            S_FREE_CLR: begin
                o_mem.cell_we    = 1'b1;
                o_mem.cell_waddr = r_wptr;
                if (r_cnt == CNT_W'(1) || r_wptr == LAST_CELL) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_cnt  = r_cnt - CNT_W'(1);
                    n_wptr = r_wptr + ADDR_W'(1);
                end
            end
            S_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_status = r_status;
                    n_rsp_start  = IDX_W'(r_start);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_wptr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wptr      <= '0;
            r_chk_v     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wptr      <= n_wptr;
            r_chk_v     <= n_chk_v;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_chk        <= n_chk;
        r_run        <= n_run;
        r_from       <= n_from;
        r_size       <= n_size;
        r_cnt        <= n_cnt;
        r_first      <= n_first;
        r_status     <= n_status;
        r_start      <= n_start;
        r_rsp_status <= n_rsp_status;
        r_rsp_start  <= n_rsp_start;
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.status     = r_rsp_status;
    assign o_rsp.base_index = r_rsp_start;

endmodule

>>> rtl/first_fit_byte_map_allocator_top.sv
// Allocate: a first-fit scan of the cell map, then one write per cell marked, then the response
// is posted from S_DONE once the output can take it; zero or oversized requests go straight to S_DONE.
// Free checks the head mark, releases one cell per write (stopping at the last cell), then responds.
// Throughput: one request at a time; the scan of the cell map, one cell per cycle, dominates.
// Reset: synchronous; a clearing pass over all HEAP_CELLS (1024) cells wipes the cell map,
// with ready held low until it ends. Block lengths are not cleared.
`include "first_fit_byte_map_allocator_top_defines.svh"

module first_fit_byte_map_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffba_req_if.sink    i_req,
    ffba_rsp_if.source  o_rsp
);
    import ffba_pkg::*;

    t_mem_req          w_mem;
    t_cell             w_cell_rd;
    logic [SIZE_W-1:0] w_len_rd;
    logic              w_fail_beat;
    logic              w_zero_start;
    logic              w_any_write;
    logic              w_head_write;

    ffba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_mem   (w_mem),
        .i_cell  (w_cell_rd),
        .i_len   (w_len_rd)
    );

    ffba_ram #(
        .WIDTH ($bits(t_cell)),
        .DEPTH (HEAP_CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.cell_we),
        .i_waddr (w_mem.cell_waddr),
        .i_wdata (w_mem.cell_wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_cell_rd)
    );

    ffba_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (HEAP_CELLS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.len_we),
        .i_waddr (w_mem.len_waddr),
        .i_wdata (w_mem.len_wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_len_rd)
    );

    assign w_fail_beat  = o_rsp.valid && (o_rsp.status != ST_OK);
    assign w_zero_start = (o_rsp.base_index == '0);
    assign w_any_write  = w_mem.cell_we || w_mem.len_we;
    assign w_head_write = w_mem.cell_we && w_mem.cell_wdata.head && w_mem.cell_wdata.used
                          && (w_mem.len_waddr == w_mem.cell_waddr);

    `FFBA_ASSERT(a_fail_start, i_clk, i_rst_n, w_fail_beat |-> w_zero_start, "start on failure")
    `FFBA_ASSERT(a_idle_quiet, i_clk, i_rst_n, i_req.ready |-> !w_any_write, "write while idle")
    `FFBA_ASSERT(a_len_at_head, i_clk, i_rst_n, w_mem.len_we |-> w_head_write, "length off a head")
    `FFBA_ASSERT_ALWAYS(a_reset_not_ready, i_clk, !i_rst_n |=> !i_req.ready, "ready during reset")

endmodule

>>> dv/testbench.sv
// Testbench for the first-fit allocator: directed and random requests checked by a predictor.
`timescale 1ns / 100ps

module testbench;
    import ffba_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  start;
    } t_alloc_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_byte_map_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bit                heap_used [HEAP_CELLS];
    bit                heap_head [HEAP_CELLS];
    logic [SIZE_W-1:0] heap_len  [HEAP_CELLS];
    int                cells_in_use;
    int                live_heads[$];
    int                last_freed;
    t_alloc_rsp        pending_rsps[$];
    int                errors;
    int                burst_left;
    int                ready_pct;
    int                ready_phase;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #120_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver stall pattern: each phase draws a random readiness level of 100, 70 or 25 percent
    always @(posedge i_clk) begin
        if (ready_phase == 0) begin
            case ($urandom_range(0, 2))
                0: ready_pct = 100;
                1: ready_pct = 70;
                default: ready_pct = 25;
            endcase
        end
        ready_phase = (ready_phase + 1) % 256;
        rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsps.size() == 0) begin
                $display("%0t: unexpected beat, status %0d base_index %0d", $time,
                         rsp_ch.status, rsp_ch.base_index);
                errors++;
            end else begin
                if (rsp_ch.status !== pending_rsps[0].status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             pending_rsps[0].status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.base_index !== pending_rsps[0].start) begin
                    $display("%0t: base_index expected %0d actual %0d", $time,
                             pending_rsps[0].start, rsp_ch.base_index);
                    errors++;
                end
                void'(pending_rsps.pop_front());
            end
        end
    end

    function automatic t_alloc_rsp apply_request(logic m, logic [SIZE_W-1:0] sz,
                                                 logic [IDX_W-1:0] idx);
        t_alloc_rsp r;
        int         run;
        int         from;
        int         found;
        int         i;
        int         stop;
        r.status = ST_NOROOM;
        r.start  = '0;
        if (m == MODE_ALLOC) begin
            found = -1;
            run   = 0;
            from  = 0;
            if (sz != 0 && sz <= HEAP_CELLS) begin
                for (i = 0; i < HEAP_CELLS && found < 0; i++) begin
                    if (!heap_used[i]) begin
                        run++;
                        if (run == sz) found = from;
                    end else begin
                        run  = 0;
                        from = i + 1;
                    end
                end
            end
            if (found >= 0) begin
                for (i = found; i < found + sz; i++) heap_used[i] = 1'b1;
                heap_head[found] = 1'b1;
                heap_len[found]  = sz;
                cells_in_use += sz;
                r.status = ST_OK;
                r.start  = found[IDX_W-1:0];
            end
        end else begin
            if (idx < HEAP_CELLS && heap_head[idx]) begin
                stop = idx + heap_len[idx];
                if (stop > HEAP_CELLS) stop = HEAP_CELLS;
                for (i = idx; i < stop; i++) begin
                    if (heap_used[i]) cells_in_use--;
                    heap_used[i] = 1'b0;
                end
                heap_head[idx] = 1'b0;
                r.status = ST_OK;
                r.start  = idx;
            end else begin
                r.status = ST_BADFREE;
            end
        end
        return r;
    endfunction

    task automatic send_request(input logic m, input int sz, input int idx);
        t_alloc_rsp r;
        int         pos[$];
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        r = apply_request(m, sz[SIZE_W-1:0], idx[IDX_W-1:0]);
        pending_rsps.push_back(r);
        if (r.status == ST_OK && m == MODE_ALLOC) live_heads.push_back(r.start);
        if (r.status == ST_OK && m == MODE_FREE) begin
            pos = live_heads.find_first_index(x) with (x == idx);
            if (pos.size() != 0) live_heads.delete(pos[0]);
            last_freed = idx;
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= m;
        req_ch.request_size <= sz[SIZE_W-1:0];
        req_ch.block_start  <= idx[IDX_W-1:0];
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_rsps.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_size_limits();
        send_request(MODE_ALLOC, 0, 0);
        send_request(MODE_ALLOC, 2047, 0);
        send_request(MODE_ALLOC, HEAP_CELLS + 1, 0);
        send_request(MODE_FREE, 0, 0);
        send_request(MODE_ALLOC, HEAP_CELLS, 0);
        send_request(MODE_ALLOC, 1, 0);
        send_request(MODE_FREE, 0, 512);
        send_request(MODE_FREE, 0, 0);
        send_request(MODE_FREE, 0, 0);
    endtask

    task automatic test_run_restart();
        send_request(MODE_ALLOC, 1, 0);
        send_request(MODE_ALLOC, 2, 0);
        send_request(MODE_ALLOC, 3, 0);
        send_request(MODE_FREE, 0, 1);
        send_request(MODE_ALLOC, 3, 0);
        send_request(MODE_ALLOC, 2, 0);
        send_request(MODE_FREE, 0, 0);
        send_request(MODE_FREE, 0, 1);
        send_request(MODE_FREE, 0, 3);
        send_request(MODE_FREE, 0, 6);
    endtask

    task automatic test_heap_edges();
        send_request(MODE_ALLOC, HEAP_CELLS - 1, 0);
        send_request(MODE_ALLOC, 1, 0);
        send_request(MODE_FREE, 0, HEAP_CELLS - 1);
        send_request(MODE_FREE, 0, HEAP_CELLS - 1);
        send_request(MODE_FREE, 0, 0);
    endtask

    task automatic test_random_churn(input int n_items);
        int pick;
        int sz;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                case ($urandom_range(0, 3))
                    0: send_request(MODE_ALLOC, 0, $urandom_range(0, HEAP_CELLS - 1));
                    1: send_request(MODE_ALLOC, $urandom_range(HEAP_CELLS + 1, 2047), 0);
                    2: send_request(MODE_FREE, $urandom_range(0, 2047),
                                    $urandom_range(0, HEAP_CELLS - 1));
                    default: send_request(MODE_FREE, 0, last_freed);
                endcase
            end else if (live_heads.size() == 0 ||
                         (cells_in_use < 3 * HEAP_CELLS / 4 && pick < 60)) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) sz = $urandom_range(1, 16);
                else if (pick < 95) sz = $urandom_range(17, 200);
                else sz = $urandom_range(201, HEAP_CELLS);
                send_request(MODE_ALLOC, sz, $urandom_range(0, HEAP_CELLS - 1));
            end else begin
                send_request(MODE_FREE, $urandom_range(0, 2047),
                             live_heads[$urandom_range(0, live_heads.size() - 1)]);
            end
        end
    endtask

    initial begin
        errors       = 0;
        burst_left   = 0;
        cells_in_use = 0;
        last_freed   = 0;
        ready_pct    = 100;
        ready_phase  = 0;
        i_rst_n             <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_ALLOC;
        req_ch.request_size <= '0;
        req_ch.block_start  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_size_limits();
        test_run_restart();
        test_heap_edges();
        wait_drained();
        test_random_churn(300);
        wait_drained();
        test_random_churn(256);
        wait_drained();
        repeat (2 * HEAP_CELLS + 8) @(posedge i_clk);

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
